[rtl/core/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants of the UTF-8 to UTF-16 decoder
// Holds the command format passed from the byte decoder to the unit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    localparam int CODE_W = 21;
    localparam int UNIT_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [CODE_W-1:0] MAX_CODE  = 21'h10FFFF;
    localparam logic [CODE_W-1:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [CODE_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CODE_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CODE_W-1:0] SUPP_BASE = 21'h010000;

    // Top six bits of the high and low surrogate units.
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    typedef enum logic [1:0] {
        CMD_UNIT,
        CMD_PAIR,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CODE_W-1:0] code;
        logic              fin;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/core/u8u16_front.sv]
// ----------------------------------------------------------------------------
// u8u16_front: byte decoder
// Tracks the open sequence, gathers code point bits and issues one command
// per byte that produces output.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [u8u16_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                         final_byte,
    output u8u16_pkg::cmd_t                   cmd,
    output logic                              push
);

    logic [u8u16_pkg::CODE_W-1:0] part_reg, part_next;
    logic [1:0]                   left_reg, left_next;
    logic                         discard_reg, discard_next;

    logic                         do_finish;
    logic                         do_err;
    logic [u8u16_pkg::CODE_W-1:0] finish_cp;
    logic [u8u16_pkg::CODE_W-1:0] shifted;
    logic                         bad_code;

    assign shifted = {part_reg[u8u16_pkg::CODE_W-7:0], data_byte[5:0]};

    // First pass: classify the byte against the sequence state.
    always_comb
    begin
        do_finish    = 1'b0;
        do_err       = 1'b0;
        finish_cp    = shifted;
        part_next    = part_reg;
        left_next    = left_reg;
        discard_next = discard_reg;
        if (discard_reg)
        begin
            if (final_byte)
            begin
                discard_next = 1'b0;
                part_next    = '0;
                left_next    = 2'd0;
            end
        end
        else if (left_reg == 2'd0)
        begin
            if (data_byte[7] == 1'b0)
            begin
                do_finish = 1'b1;
                finish_cp = {{(u8u16_pkg::CODE_W-u8u16_pkg::BYTE_W){1'b0}}, data_byte};
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                part_next = {{(u8u16_pkg::CODE_W-5){1'b0}}, data_byte[4:0]};
                left_next = 2'd1;
                do_err    = final_byte;
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                part_next = {{(u8u16_pkg::CODE_W-4){1'b0}}, data_byte[3:0]};
                left_next = 2'd2;
                do_err    = final_byte;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                part_next = {{(u8u16_pkg::CODE_W-3){1'b0}}, data_byte[2:0]};
                left_next = 2'd3;
                do_err    = final_byte;
            end
            else
            begin
                do_err = 1'b1;
            end
        end
        else if (data_byte[7:6] != 2'b10)
        begin
            do_err = 1'b1;
        end
        else
        begin
            part_next = shifted;
            left_next = left_reg - 2'd1;
            if (left_reg == 2'd1)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                do_err = final_byte;
            end
        end
    end

    assign bad_code = (finish_cp > u8u16_pkg::MAX_CODE) ||
                      ((finish_cp >= u8u16_pkg::SURR_LO) && (finish_cp <= u8u16_pkg::SURR_HI));

    // Second pass: turn the classification into a command and a state update.
    always_comb
    begin
        cmd.kind = u8u16_pkg::CMD_ERROR;
        cmd.code = finish_cp;
        cmd.fin  = final_byte;
        push     = 1'b0;
        if (do_err || (do_finish && bad_code))
        begin
            push = accept;
        end
        else if (do_finish)
        begin
            push     = accept;
            cmd.kind = (finish_cp <= u8u16_pkg::BMP_MAX) ? u8u16_pkg::CMD_UNIT
                                                         : u8u16_pkg::CMD_PAIR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg    <= '0;
            left_reg    <= 2'd0;
            discard_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (do_err || (do_finish && bad_code))
            begin
                part_reg    <= '0;
                left_reg    <= 2'd0;
                discard_reg <= !final_byte;
            end
            else if (do_finish)
            begin
                part_reg    <= '0;
                left_reg    <= 2'd0;
                discard_reg <= discard_next;
            end
            else
            begin
                part_reg    <= part_next;
                left_reg    <= left_next;
                discard_reg <= discard_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/u8u16_queue.sv]
// ----------------------------------------------------------------------------
// u8u16_queue: command queue
// Small register FIFO that decouples the byte decoder from the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u8u16_pkg::cmd_t push_cmd,
    input  wire logic            pop,
    output u8u16_pkg::cmd_t      head_cmd,
    output logic                 not_empty,
    output logic                 not_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/u8u16_back.sv]
// ----------------------------------------------------------------------------
// u8u16_back: unit emitter
// Turns each command into one or two result beats held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire u8u16_pkg::cmd_t              head_cmd,
    input  wire logic                         head_valid,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [u8u16_pkg::UNIT_W-1:0]      code_unit,
    output logic                              is_error,
    output logic                              run_last,
    output logic                              string_done
);

    logic                         out_valid_reg;
    logic                         half_reg, half_next;
    logic [u8u16_pkg::UNIT_W-1:0] unit_reg, unit_next;
    logic                         err_reg, err_next;
    logic                         last_reg, last_next;
    logic                         done_reg;
    logic                         load;
    logic [u8u16_pkg::CODE_W-1:0] offset;

    assign load   = head_valid && (!out_valid_reg || out_ready);
    assign offset = head_cmd.code - u8u16_pkg::SUPP_BASE;

    always_comb
    begin
        unit_next = '0;
        err_next  = 1'b0;
        last_next = 1'b1;
        half_next = half_reg;
        pop       = 1'b0;
        unique case (head_cmd.kind)
            u8u16_pkg::CMD_UNIT:
            begin
                unit_next = head_cmd.code[u8u16_pkg::UNIT_W-1:0];
                pop       = load;
            end
            u8u16_pkg::CMD_PAIR:
            begin
                if (half_reg)
                begin
                    unit_next = {u8u16_pkg::LO_SURR_TAG, head_cmd.code[9:0]};
                    pop       = load;
                    half_next = !load;
                end
                else
                begin
                    unit_next = {u8u16_pkg::HI_SURR_TAG, offset[19:10]};
                    last_next = 1'b0;
                    half_next = load;
                end
            end
            default:
            begin
                err_next = 1'b1;
                pop      = load;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= unit_next;
            err_reg  <= err_next;
            last_reg <= last_next;
            done_reg <= head_cmd.fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_unit   = unit_reg;
    assign is_error    = err_reg;
    assign run_last    = last_reg;
    assign string_done = done_reg;

endmodule

`default_nettype wire

[rtl/core/utf8_to_utf16_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit: UTF-8 to UTF-16 decoder, top level
// A byte that ends a code point is written into the queue and then loaded
// into the output register; a pair fills two beats, high surrogate first.
// Throughput: one byte per cycle while the queue has room and one result beat
// per cycle while out_ready is high, set by the emitter's one output register.
// Reset: rst_n clears the sequence state, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

// The byte decoder updates the sequence state on every accepted beat and
// pushes a command whenever the byte completes a code point or detects an
// error. Bytes that only extend a sequence, and bytes dropped after an error,
// push nothing. The queue lets the decoder keep taking bytes while the emitter
// is stalled on the output or busy with the second half of a surrogate pair.
module utf8_to_utf16_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic             is_error,
    output logic             run_last,
    output logic             string_done
);

    u8u16_pkg::cmd_t push_cmd;
    u8u16_pkg::cmd_t head_cmd;
    logic            push;
    logic            pop;
    logic            not_empty;
    logic            not_full;
    logic            accept;

    // A byte is taken only when the queue has room for the command it might
    // produce, so no command is ever lost.
    assign in_ready = not_full;
    assign accept   = in_valid && not_full;

    u8u16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cmd        (push_cmd),
        .push       (push)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    // The emitter pops a command once its last result beat is loaded into the
    // output register.
    u8u16_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .head_valid  (not_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_unit   (code_unit),
        .is_error    (is_error),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

`default_nettype wire
